FILE: hdl/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types, constants and the CRC-16 byte update for the answer-frame
// checker.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  // Byte counter saturates at MAX_FRAME_BYTES + 1.
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);
  localparam int LEN_W = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] MODE_MASK = 8'h0F;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_CODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_BYTE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_ADDRESS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_TYPE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX     = 3'd6;

  // Element data types.
  localparam logic [2:0] DT_BITS  = 3'd0;
  localparam logic [2:0] DT_BYTE  = 3'd1;
  localparam logic [2:0] DT_WORD  = 3'd2;
  localparam logic [2:0] DT_DWORD = 3'd3;
  localparam logic [2:0] DT_FLOAT = 3'd4;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TIMEOUT = 3'd1,
    ST_LENGTH  = 3'd2,
    ST_HEADER  = 3'd3,
    ST_CRC     = 3'd4,
    ST_ECHO    = 3'd5
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] answer_byte;
  } in_item_t;

  typedef struct packed {
    logic        is_status;
    logic [2:0]  status;
    logic [31:0] element_value;
    logic [15:0] element_index;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] expected_length;
    logic [7:0]       node_address;
    logic [7:0]       function_code;
    logic [7:0]       control_byte;
    logic [15:0]      request_address;
    logic [2:0]       data_type;
    logic [15:0]      start_index;
  } cfg_t;

  // Results caused by one input item, handed to the output stage.
  typedef struct packed {
    logic        is_status;
    logic [2:0]  status;
    logic [31:0] value;
    logic [15:0] base_index;
    logic        bit_mode;
  } batch_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hdl/rfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// rfc_cfg_regs
// Configuration register file holding the request that the answer is
// checked against.
// ----------------------------------------------------------------------------
module rfc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rfc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output rfc_pkg::cfg_t                   cfg
);

  rfc_pkg::cfg_t cfg_r;
  rfc_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rfc_pkg::CFG_EXPECTED_LENGTH:
          cfg_nxt.expected_length = cfg_data[rfc_pkg::LEN_W-1:0];
        rfc_pkg::CFG_NODE_ADDRESS:    cfg_nxt.node_address = cfg_data[7:0];
        rfc_pkg::CFG_FUNCTION_CODE:   cfg_nxt.function_code = cfg_data[7:0];
        rfc_pkg::CFG_CONTROL_BYTE:    cfg_nxt.control_byte = cfg_data[7:0];
        rfc_pkg::CFG_REQUEST_ADDRESS: cfg_nxt.request_address = cfg_data;
        rfc_pkg::CFG_DATA_TYPE:       cfg_nxt.data_type = cfg_data[2:0];
        rfc_pkg::CFG_START_INDEX:     cfg_nxt.start_index = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_length <= rfc_pkg::LEN_W'(6);
      cfg_r.node_address    <= 8'h00;
      cfg_r.function_code   <= 8'h43;
      cfg_r.control_byte    <= 8'h00;
      cfg_r.request_address <= 16'h0000;
      cfg_r.data_type       <= rfc_pkg::DT_BITS;
      cfg_r.start_index     <= 16'h0000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hdl/rfc_frame_check.sv
// ----------------------------------------------------------------------------
// rfc_frame_check
// Input register and per-byte frame checking: CRC, header and echo compare,
// element assembly and final status.
// ----------------------------------------------------------------------------
module rfc_frame_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rfc_pkg::in_item_t   in_data,
  input  rfc_pkg::cfg_t       cfg,
  input  logic                emit_ready,
  output logic                batch_load,
  output rfc_pkg::batch_t     batch
);

  localparam int CW = rfc_pkg::CNT_W;
  localparam int LW = rfc_pkg::LEN_W;

  logic              in_valid_r, in_valid_nxt;
  rfc_pkg::in_item_t in_r;

  logic [CW-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic          header_bad_r, header_bad_nxt;
  logic          address_bad_r, address_bad_nxt;
  logic [23:0]   asm_r, asm_nxt;
  logic [15:0]   elem_cnt_r, elem_cnt_nxt;

  logic          is_write;
  logic          in_window;
  logic          has_result;
  logic          go;
  logic          accept;
  logic [7:0]    b;
  logic [15:0]   word_v;
  rfc_pkg::status_t st;

  assign b = in_r.answer_byte;
  assign is_write = (cfg.control_byte & rfc_pkg::MODE_MASK) != 8'h00;
  assign in_window = !is_write && (byte_count_r >= CW'(4)) &&
                     ((LW + 1)'(byte_count_r) + (LW + 1)'(2) <
                      {1'b0, cfg.expected_length});
  assign word_v = {b, asm_r[7:0]};

  // An item that yields no result never waits for the output stage.
  assign go = in_valid_r && (emit_ready || !has_result);
  assign batch_load = go && has_result;
  assign in_stall = in_valid_r && !go;
  assign accept = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (go) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    byte_count_nxt  = byte_count_r;
    crc_nxt         = crc_r;
    header_bad_nxt  = header_bad_r;
    address_bad_nxt = address_bad_r;
    asm_nxt         = asm_r;
    elem_cnt_nxt    = elem_cnt_r;
    has_result      = 1'b0;
    batch           = '0;
    batch.base_index = cfg.start_index + elem_cnt_r;
    st = rfc_pkg::ST_OK;

    if (byte_count_r == CW'(0)) begin
      st = rfc_pkg::ST_TIMEOUT;
    end else if (byte_count_r > CW'(rfc_pkg::MAX_FRAME_BYTES) ||
                 LW'(byte_count_r) != cfg.expected_length) begin
      st = rfc_pkg::ST_LENGTH;
    end else if (header_bad_r) begin
      st = rfc_pkg::ST_HEADER;
    end else if (crc_r != 16'h0000) begin
      st = rfc_pkg::ST_CRC;
    end else if (is_write && address_bad_r) begin
      st = rfc_pkg::ST_ECHO;
    end

    if (in_r.kind) begin
      has_result       = 1'b1;
      batch.is_status  = 1'b1;
      batch.status     = st;
      batch.base_index = 16'h0000;
      byte_count_nxt   = '0;
      crc_nxt          = rfc_pkg::CRC_INIT;
      header_bad_nxt   = 1'b0;
      address_bad_nxt  = 1'b0;
      asm_nxt          = '0;
      elem_cnt_nxt     = '0;
    end else if (byte_count_r >= CW'(rfc_pkg::MAX_FRAME_BYTES)) begin
      // Overlong frame: the byte is dropped and the count pins past the bound.
      byte_count_nxt = CW'(rfc_pkg::MAX_FRAME_BYTES + 1);
    end else begin
      byte_count_nxt = byte_count_r + CW'(1);
      crc_nxt = rfc_pkg::crc_feed(crc_r, b);
      if ((byte_count_r == CW'(0) && b != cfg.node_address) ||
          (byte_count_r == CW'(1) && b != cfg.function_code) ||
          (byte_count_r == CW'(2) && b != cfg.control_byte)) begin
        header_bad_nxt = 1'b1;
      end
      if ((byte_count_r == CW'(3) && b != cfg.request_address[15:8]) ||
          (byte_count_r == CW'(4) && b != cfg.request_address[7:0])) begin
        address_bad_nxt = 1'b1;
      end
      if (in_window) begin
        // Byte position within the data area has the same low bits as the count.
        case (cfg.data_type) inside
          rfc_pkg::DT_BITS: begin
            has_result     = 1'b1;
            batch.bit_mode = 1'b1;
            batch.value    = {24'h000000, b};
            elem_cnt_nxt   = elem_cnt_r + 16'd8;
          end
          rfc_pkg::DT_BYTE: begin
            has_result   = 1'b1;
            batch.value  = {{24{b[7]}}, b};
            elem_cnt_nxt = elem_cnt_r + 16'd1;
          end
          rfc_pkg::DT_WORD: begin
            if (!byte_count_r[0]) begin
              asm_nxt = {16'h0000, b};
            end else begin
              has_result   = 1'b1;
              batch.value  = {{16{word_v[15]}}, word_v};
              elem_cnt_nxt = elem_cnt_r + 16'd1;
            end
          end
          rfc_pkg::DT_DWORD, rfc_pkg::DT_FLOAT: begin
            case (byte_count_r[1:0])
              2'd0: asm_nxt = {16'h0000, b};
              2'd1: asm_nxt = asm_r | {8'h00, b, 8'h00};
              2'd2: asm_nxt = asm_r | {b, 16'h0000};
              default: begin
                has_result   = 1'b1;
                batch.value  = {b, asm_r};
                elem_cnt_nxt = elem_cnt_r + 16'd1;
              end
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      byte_count_r  <= '0;
      crc_r         <= rfc_pkg::CRC_INIT;
      header_bad_r  <= 1'b0;
      address_bad_r <= 1'b0;
      asm_r         <= '0;
      elem_cnt_r    <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (go) begin
        byte_count_r  <= byte_count_nxt;
        crc_r         <= crc_nxt;
        header_bad_r  <= header_bad_nxt;
        address_bad_r <= address_bad_nxt;
        asm_r         <= asm_nxt;
        elem_cnt_r    <= elem_cnt_nxt;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= CW'(rfc_pkg::MAX_FRAME_BYTES + 1))
    else $error("byte count beyond saturation value");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    go && in_r.kind |=> byte_count_r == '0 && crc_r == rfc_pkg::CRC_INIT &&
                        elem_cnt_r == 16'h0000)
    else $error("frame state not cleared after end of frame");

endmodule

FILE: hdl/rfc_emitter.sv
// ----------------------------------------------------------------------------
// rfc_emitter
// Output register: holds the results of one item and hands them out one
// transfer at a time, eight for a byte in bit mode.
// ----------------------------------------------------------------------------
module rfc_emitter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               batch_load,
  input  rfc_pkg::batch_t    batch,
  output logic               emit_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output rfc_pkg::out_item_t out_data
);

  logic            valid_r, valid_nxt;
  rfc_pkg::batch_t batch_r;
  logic [2:0]      pos_r, pos_nxt;
  logic            take;

  assign out_valid = valid_r;
  assign take = valid_r && !out_stall;
  assign emit_ready = !valid_r || (take && out_data.last);

  always_comb begin
    out_data.is_status     = batch_r.is_status;
    out_data.status        = batch_r.status;
    out_data.element_value = batch_r.bit_mode ? {31'h0, batch_r.value[pos_r]} : batch_r.value;
    out_data.element_index = batch_r.bit_mode ? batch_r.base_index + 16'(pos_r)
                                              : batch_r.base_index;
    out_data.last          = !batch_r.bit_mode || pos_r == 3'd7;
  end

  always_comb begin
    valid_nxt = valid_r;
    pos_nxt   = pos_r;
    if (batch_load) begin
      valid_nxt = 1'b1;
      pos_nxt   = 3'd0;
    end else if (take) begin
      if (out_data.last) begin
        valid_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (batch_load) begin
      batch_r <= batch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= 3'd0;
    end else begin
      valid_r <= valid_nxt;
      pos_r   <= pos_nxt;
    end
  end

  a_pos_bits_only: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !batch_r.bit_mode |-> pos_r == 3'd0)
    else $error("element position advanced outside bit mode");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_status |-> out_data.last)
    else $error("status result not marked last");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    take && !out_data.last |=> valid_r && pos_r == $past(pos_r) + 3'd1)
    else $error("bit element sequence broken");

endmodule

FILE: hdl/response_frame_checker_core.sv
// ----------------------------------------------------------------------------
// response_frame_checker_core
// Checks a slave answer frame against its request and unpacks read data.
// ----------------------------------------------------------------------------
// Each answer byte passes an input register, then the checking logic
// (CRC-16 byte update, header and echo compare, element assembly) into an
// output register. Bytes that give at most one result, and end-of-frame
// items, flow at one item per cycle while out_stall is low. In bit mode a
// data byte gives eight elements that leave the output register one per
// cycle while out_stall is low; a later item with a result waits until the
// last of them is taken. Elements are tentative until the frame status
// that follows them reports ok. The user must write configuration only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module response_frame_checker_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rfc_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rfc_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rfc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rfc_pkg::cfg_t   cfg;
  rfc_pkg::batch_t batch;
  logic            batch_load;
  logic            emit_ready;

  rfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rfc_frame_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg        (cfg),
    .emit_ready (emit_ready),
    .batch_load (batch_load),
    .batch      (batch)
  );

  rfc_emitter u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .batch_load (batch_load),
    .batch      (batch),
    .emit_ready (emit_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Answer-frame checker testbench
// Feeds answer frames (well-formed, damaged and noise) through the checker
// under many register settings, predicts every unpacked element and every
// frame status, and compares each result transfer against the prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rfc_pkg::*;

  localparam int CLK_HALF_NS = 5;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 100;
  localparam int MIN_PHASES = 5;
  localparam int SETTLE_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

  typedef enum int {
    FRAME_GOOD,
    FRAME_SHORT,
    FRAME_LONG,
    FRAME_BAD_HEADER,
    FRAME_BAD_CRC,
    FRAME_BAD_ECHO,
    FRAME_EMPTY,
    FRAME_NOISE,
    FRAME_OVERRUN
  } frame_fault_t;

  class frame_scoreboard;
    // Register shadow.
    logic [LEN_W-1:0] exp_len;
    logic [7:0]       node;
    logic [7:0]       func;
    logic [7:0]       ctrl;
    logic [15:0]      req_addr;
    logic [2:0]       dtype;
    logic [15:0]      first_index;
    // Per-frame state.
    int unsigned      nbytes;
    logic [15:0]      crc;
    bit               hdr_bad;
    bit               echo_bad;
    logic [23:0]      asm_word;
    logic [15:0]      elem_count;

    out_item_t        due_results[$];
    int               errors;

    function new();
      exp_len = 9'd6;
      node = 8'h00;
      func = 8'h43;
      ctrl = 8'h00;
      req_addr = 16'h0000;
      dtype = DT_BITS;
      first_index = 16'h0000;
      errors = 0;
      clear_frame();
    endfunction

    static function logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] data);
      logic [15:0] c;
      c = crc_in ^ {8'h00, data};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void clear_frame();
      nbytes = 0;
      crc = CRC_INIT;
      hdr_bad = 1'b0;
      echo_bad = 1'b0;
      asm_word = '0;
      elem_count = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_EXPECTED_LENGTH: exp_len = value[LEN_W-1:0];
        CFG_NODE_ADDRESS:    node = value[7:0];
        CFG_FUNCTION_CODE:   func = value[7:0];
        CFG_CONTROL_BYTE:    ctrl = value[7:0];
        CFG_REQUEST_ADDRESS: req_addr = value;
        CFG_DATA_TYPE:       dtype = value[2:0];
        CFG_START_INDEX:     first_index = value;
        default: ;
      endcase
    endfunction

    function void push_element(logic [31:0] v);
      out_item_t r;
      r = '0;
      r.element_value = v;
      r.element_index = first_index + elem_count;
      elem_count = elem_count + 16'd1;
      due_results.push_back(r);
    endfunction

    function void decode_item(in_item_t it);
      logic [7:0]  b;
      int unsigned pos;
      int unsigned p;
      bit          writing;
      int          n;
      status_t     st;
      out_item_t   r;
      b = it.answer_byte;
      writing = (ctrl & MODE_MASK) != 8'h00;
      n = 0;
      if (it.kind) begin
        if (nbytes == 0) st = ST_TIMEOUT;
        else if (nbytes > MAX_FRAME_BYTES || nbytes != exp_len) st = ST_LENGTH;
        else if (hdr_bad) st = ST_HEADER;
        else if (crc != 16'h0000) st = ST_CRC;
        else if (writing && echo_bad) st = ST_ECHO;
        else st = ST_OK;
        r = '0;
        r.is_status = 1'b1;
        r.status = st;
        r.last = 1'b1;
        due_results.push_back(r);
        clear_frame();
        return;
      end
      // Bytes past the frame bound are dropped; the count sticks one above it.
      if (nbytes >= MAX_FRAME_BYTES) begin
        nbytes = MAX_FRAME_BYTES + 1;
        return;
      end
      pos = nbytes;
      nbytes = nbytes + 1;
      crc = crc16_byte(crc, b);
      if (pos == 0 && b != node) hdr_bad = 1'b1;
      if (pos == 1 && b != func) hdr_bad = 1'b1;
      if (pos == 2 && b != ctrl) hdr_bad = 1'b1;
      if (pos == 3 && b != req_addr[15:8]) echo_bad = 1'b1;
      if (pos == 4 && b != req_addr[7:0]) echo_bad = 1'b1;
      if (!writing && pos >= 4 && pos + 2 < exp_len) begin
        p = pos - 4;
        case (dtype)
          DT_BITS: begin
            for (int k = 0; k < 8; k++) begin
              push_element({31'b0, b[k]});
              n++;
            end
          end
          DT_BYTE: begin
            push_element({{24{b[7]}}, b});
            n++;
          end
          DT_WORD: begin
            if (p % 2 == 0) begin
              asm_word = {16'h0000, b};
            end else begin
              push_element({{16{b[7]}}, b, asm_word[7:0]});
              n++;
            end
          end
          DT_DWORD, DT_FLOAT: begin
            case (p % 4)
              0: asm_word = {16'h0000, b};
              1: asm_word = asm_word | {8'h00, b, 8'h00};
              2: asm_word = asm_word | {b, 16'h0000};
              default: begin
                push_element({b, asm_word});
                n++;
              end
            endcase
          end
          default: ;
        endcase
      end
      if (n > 0) due_results[due_results.size()-1].last = 1'b1;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      bit        bad;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result: is_status=%0b status=%0d value=%h index=%h last=%0b",
                   $realtime, got.is_status, got.status, got.element_value,
                   got.element_index, got.last);
        return;
      end
      want = due_results.pop_front();
      bad = (got.is_status !== want.is_status) || (got.status !== want.status) ||
            (got.element_value !== want.element_value) ||
            (got.element_index !== want.element_index) || (got.last !== want.last);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected: is_status=%0b status=%0d value=%h index=%h last=%0b",
                   want.is_status, want.status, want.element_value,
                   want.element_index, want.last);
          $display("  actual:   is_status=%0b status=%0d value=%h index=%h last=%0b",
                   got.is_status, got.status, got.element_value,
                   got.element_index, got.last);
        end
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_scoreboard sb;
  int unsigned     cycle_count = 0;
  int unsigned     items_sent = 0;
  int              burst_left = 0;
  bit              valid_up = 1'b0;
  int              stall_mode = 0;
  int              stall_span = 0;
  int unsigned     stall_tick = 0;

  response_frame_checker_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Values read right after the edge are the ones the block saw at that edge.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid && !in_stall) sb.decode_item(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Receiver: free-flowing, light random, heavy random and periodic stretches.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(10, 80);
    end
    stall_span--;
    stall_tick++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ($urandom_range(0, 99) < 75);
      default: out_stall <= (stall_tick % 4 != 0);
    endcase
  end

  task automatic send_item(input logic kind_v, input logic [7:0] byte_v);
    in_item_t it;
    it.kind = kind_v;
    it.answer_byte = byte_v;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
      valid_up = 1'b1;
    end else begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Holds the sender off until every predicted result has been seen. It waits
  // on the clock first so that the last accepted item is already predicted.
  task automatic wait_drained();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
  endtask

  // Sometimes sets bits above a register's width; the block must ignore them.
  function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned value, int width);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'(value);
    if (width < CFG_DATA_W && $urandom_range(0, 3) == 0)
      v = v | (CFG_DATA_W'($urandom) << width);
    return v;
  endfunction

  task automatic configure(input int unsigned len, input logic [7:0] node_v,
                           input logic [7:0] func_v, input logic [7:0] ctrl_v,
                           input logic [15:0] addr_v, input logic [2:0] dt_v,
                           input logic [15:0] start_v);
    write_reg(CFG_EXPECTED_LENGTH, with_junk(len, LEN_W));
    write_reg(CFG_NODE_ADDRESS, with_junk(node_v, 8));
    write_reg(CFG_FUNCTION_CODE, with_junk(func_v, 8));
    write_reg(CFG_CONTROL_BYTE, with_junk(ctrl_v, 8));
    write_reg(CFG_REQUEST_ADDRESS, addr_v);
    write_reg(CFG_DATA_TYPE, with_junk(dt_v, 3));
    write_reg(CFG_START_INDEX, start_v);
    write_reg(CFG_UNUSED_INDEX, 16'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input frame_fault_t fault);
    logic [7:0]  fr[$];
    logic [15:0] crc;
    int          len;
    int          idx;
    int          hi;
    bit          writing;
    fr = {};
    writing = (sb.ctrl & MODE_MASK) != 8'h00;
    if (fault == FRAME_OVERRUN) len = MAX_FRAME_BYTES;
    else if (sb.exp_len >= 2 && sb.exp_len <= MAX_FRAME_BYTES) len = int'(sb.exp_len);
    else len = $urandom_range(6, 12);
    if (fault == FRAME_NOISE) begin
      repeat ($urandom_range(1, 12)) fr.push_back(8'($urandom_range(0, 255)));
    end else if (fault != FRAME_EMPTY) begin
      for (int i = 0; i < len - 2; i++) begin
        case (i)
          0: fr.push_back(sb.node);
          1: fr.push_back(sb.func);
          2: fr.push_back(sb.ctrl);
          3: fr.push_back(writing ? sb.req_addr[15:8] : 8'($urandom_range(0, 255)));
          4: fr.push_back(writing ? sb.req_addr[7:0] : 8'($urandom_range(0, 255)));
          default: fr.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      // The echo is damaged before the CRC is formed, so only the echo is wrong.
      if (fault == FRAME_BAD_ECHO && fr.size() > 3) begin
        hi = (fr.size() > 4) ? 4 : 3;
        idx = $urandom_range(3, hi);
        fr[idx] = fr[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
      crc = CRC_INIT;
      foreach (fr[i]) crc = frame_scoreboard::crc16_byte(crc, fr[i]);
      fr.push_back(crc[7:0]);
      fr.push_back(crc[15:8]);
      case (fault)
        FRAME_SHORT: fr.delete($urandom_range(0, fr.size() - 1));
        FRAME_LONG: fr.insert($urandom_range(0, fr.size()), 8'($urandom_range(0, 255)));
        FRAME_BAD_HEADER: begin
          hi = (fr.size() > 3) ? 2 : fr.size() - 1;
          idx = $urandom_range(0, hi);
          fr[idx] = fr[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        FRAME_BAD_CRC: begin
          idx = (fr.size() > 3) ? $urandom_range(3, fr.size() - 1)
                                : $urandom_range(0, fr.size() - 1);
          fr[idx] = fr[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        FRAME_OVERRUN:
          repeat ($urandom_range(1, 4)) fr.push_back(8'($urandom_range(0, 255)));
        default: ;
      endcase
    end
    foreach (fr[i]) send_item(1'b0, fr[i]);
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'hFFF0 | 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] pick_control();
    logic [3:0] mode;
    mode = ($urandom_range(0, 9) < 6) ? 4'h0 : 4'($urandom_range(1, 15));
    return {4'($urandom_range(0, 15)), mode};
  endfunction

  task automatic random_phase(input int phase_no);
    int unsigned      len;
    int               r;
    logic [2:0]       dt_v;
    frame_fault_t     fault;
    r = $urandom_range(0, 99);
    if (r < 5) len = $urandom_range(0, 5);
    else if (r < 15) len = $urandom_range(257, 511);
    else if (r < 25) len = $urandom_range(6, 7);
    else len = $urandom_range(8, 20);
    if (phase_no < 8) dt_v = 3'(phase_no);
    else if ($urandom_range(0, 9) == 0) dt_v = 3'($urandom_range(5, 7));
    else dt_v = 3'($urandom_range(0, 4));
    configure(len, pick_byte(), pick_byte(), pick_control(), pick_word(), dt_v, pick_word());
    repeat ($urandom_range(1, 5)) begin
      r = $urandom_range(0, 99);
      if (r < 60) fault = FRAME_GOOD;
      else fault = frame_fault_t'($urandom_range(FRAME_SHORT, FRAME_NOISE));
      send_frame(fault);
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    int unsigned base;
    int          phase_no;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty frame, minimal frame at reset settings, a bit-mode read
    // whose indexes wrap, and a write whose address echo is wrong.
    send_frame(FRAME_EMPTY);
    send_frame(FRAME_GOOD);
    wait_drained();
    configure(8, 8'hFF, 8'h00, 8'h00, 16'h0000, DT_BITS, 16'hFFFC);
    send_frame(FRAME_GOOD);
    wait_drained();
    configure(6, 8'h5A, 8'h43, 8'hF1, 16'hFFFF, DT_WORD, 16'h0000);
    send_frame(FRAME_BAD_ECHO);
    wait_drained();

    base = items_sent;
    phase_no = 0;
    while (items_sent - base < RANDOM_ITEMS || phase_no < MIN_PHASES) begin
      random_phase(phase_no);
      phase_no++;
    end

    // A full-length frame that runs on past the bound.
    configure(MAX_FRAME_BYTES, pick_byte(), pick_byte(), {4'($urandom_range(0, 15)), 4'h0},
              pick_word(), 3'($urandom_range(0, 4)), pick_word());
    send_frame(FRAME_OVERRUN);
    wait_drained();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
